>>> hw/rtl/xon_xoff_flow_control_top_macros.svh
// Assertion macros shared by the XON/XOFF flow control RTL.
// Included by the modules that carry concurrent assertions; no other dependency.
`ifndef XON_XOFF_FLOW_CONTROL_TOP_MACROS_SVH
`define XON_XOFF_FLOW_CONTROL_TOP_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define XXFC_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("xxfc assertion failed");
// Condition that must hold in the cycle after the antecedent.
`define XXFC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("xxfc assertion failed");
`else
`define XXFC_ASSERT(lbl, ck, rn, prop)
`define XXFC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> hw/rtl/xxfc_pkg.sv
// Package for the XON/XOFF flow control block: payload types, codes, defaults.
// Used by every module of the block; depends on nothing.
`default_nettype none

package xxfc_pkg;

    // Default queue depths.
    localparam int RX_DEPTH_DEF = 32;
    localparam int TX_DEPTH_DEF = 512;

    // Field widths fixed by the interface.
    localparam int BYTE_W   = 8;
    localparam int THR_W    = 6;
    localparam int RX_LVL_W = 6;
    localparam int TX_LVL_W = 10;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Flow control characters.
    localparam logic [BYTE_W-1:0] CODE_XON  = 8'd17;
    localparam logic [BYTE_W-1:0] CODE_XOFF = 8'd19;

    // Register reset values.
    localparam logic [1:0]       FLOW_MODE_RST = 2'd1;
    localparam logic [THR_W-1:0] HIGH_THR_RST  = 6'd20;
    localparam logic [THR_W-1:0] LOW_THR_RST   = 6'd12;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_FLOW_MODE = 2'd0;
    localparam logic [1:0] REG_HIGH_THR  = 2'd1;
    localparam logic [1:0] REG_LOW_THR   = 2'd2;

    // Input opcodes.
    localparam logic [1:0] OP_LINE_BYTE  = 2'd0;
    localparam logic [1:0] OP_HOST_READ  = 2'd1;
    localparam logic [1:0] OP_HOST_WRITE = 2'd2;
    localparam logic [1:0] OP_TICK       = 2'd3;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;

    // Classified command kinds.
    typedef enum logic [2:0] {
        KIND_RX_DATA,
        KIND_RX_CTRL,
        KIND_HOST_READ,
        KIND_HOST_WRITE,
        KIND_TICK
    } kind_t;

    // Which store feeds the result byte once the read data is back.
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_RX,
        SEL_TX
    } sel_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic                line_tx_valid;
        logic [BYTE_W-1:0]   line_tx_byte;
        logic                host_rx_valid;
        logic [BYTE_W-1:0]   host_rx_byte;
        logic [RX_LVL_W-1:0] rx_level;
        logic [TX_LVL_W-1:0] tx_level;
        logic                sending_enabled;
        logic                dropped;
    } result_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       flow_mode;
        logic [THR_W-1:0] high_threshold;
        logic [THR_W-1:0] low_threshold;
        logic             send_on_set;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/xxfc_regs.sv
// APB configuration registers: flow mode and the two receive thresholds.
// Depends on xxfc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module xxfc_regs (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [xxfc_pkg::PADDR_W-1:0]   paddr,
    input  wire [xxfc_pkg::PDATA_W-1:0]   pwdata,
    output logic [xxfc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output xxfc_pkg::cfg_t                cfg
);

    logic [1:0]                   flow_mode_reg;
    logic [xxfc_pkg::THR_W-1:0]   high_thr_reg;
    logic [xxfc_pkg::THR_W-1:0]   low_thr_reg;
    logic                         send_on_set_reg;
    logic                         wr_en;
    logic [1:0]                   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[xxfc_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes; clearing the flow mode releases a pause.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_mode_reg   <= xxfc_pkg::FLOW_MODE_RST;
            high_thr_reg    <= xxfc_pkg::HIGH_THR_RST;
            low_thr_reg     <= xxfc_pkg::LOW_THR_RST;
            send_on_set_reg <= 1'b0;
        end
        else
        begin
            send_on_set_reg <= wr_en && (reg_idx == xxfc_pkg::REG_FLOW_MODE) &&
                               (pwdata[1:0] == 2'd0);
            if (wr_en)
            begin
                unique case (reg_idx)
                    xxfc_pkg::REG_FLOW_MODE: flow_mode_reg <= pwdata[1:0];
                    xxfc_pkg::REG_HIGH_THR: high_thr_reg <= pwdata[xxfc_pkg::THR_W-1:0];
                    xxfc_pkg::REG_LOW_THR:  low_thr_reg  <= pwdata[xxfc_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_idx)
            xxfc_pkg::REG_FLOW_MODE: prdata = xxfc_pkg::PDATA_W'(flow_mode_reg);
            xxfc_pkg::REG_HIGH_THR:  prdata = xxfc_pkg::PDATA_W'(high_thr_reg);
            xxfc_pkg::REG_LOW_THR:   prdata = xxfc_pkg::PDATA_W'(low_thr_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.flow_mode      = flow_mode_reg;
    assign cfg.high_threshold = high_thr_reg;
    assign cfg.low_threshold  = low_thr_reg;
    assign cfg.send_on_set    = send_on_set_reg;

endmodule

`default_nettype wire

>>> hw/rtl/xxfc_front.sv
// Front end: accepts input items and classifies them into commands.
// Depends on xxfc_pkg for item_t, cmd_t and the opcode and kind codes.
`default_nettype none

module xxfc_front (
    input  wire                  item_valid,
    output logic                 item_stall,
    input  xxfc_pkg::item_t      item,
    input  wire                  flow_on,
    input  wire                  q_full,
    output logic                 q_push,
    output xxfc_pkg::cmd_t       q_cmd
);

    logic is_ctrl_byte;

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    // XON and XOFF are control bytes only while flow control is on.
    assign is_ctrl_byte = flow_on && ((item.data_byte == xxfc_pkg::CODE_XON) ||
                                      (item.data_byte == xxfc_pkg::CODE_XOFF));

    // Opcode decode.
    always_comb
    begin
        q_cmd.data = item.data_byte;
        unique case (item.opcode)
            xxfc_pkg::OP_LINE_BYTE:
                q_cmd.kind = is_ctrl_byte ? xxfc_pkg::KIND_RX_CTRL : xxfc_pkg::KIND_RX_DATA;
            xxfc_pkg::OP_HOST_READ:  q_cmd.kind = xxfc_pkg::KIND_HOST_READ;
            xxfc_pkg::OP_HOST_WRITE: q_cmd.kind = xxfc_pkg::KIND_HOST_WRITE;
            default:                 q_cmd.kind = xxfc_pkg::KIND_TICK;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/xxfc_queue.sv
// Short command queue between the front end and the back end.
// Depends on xxfc_pkg for cmd_t and the queue depth.
`default_nettype none

module xxfc_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  xxfc_pkg::cmd_t     push_cmd,
    output logic               full,
    input  wire                pop,
    output logic               head_valid,
    output xxfc_pkg::cmd_t     head
);

    localparam int AW = (xxfc_pkg::Q_DEPTH > 1) ? $clog2(xxfc_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(xxfc_pkg::Q_DEPTH + 1);

    xxfc_pkg::cmd_t  entry_reg [xxfc_pkg::Q_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full       = (count_reg == CW'(xxfc_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(xxfc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(xxfc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/xxfc_back.sv
// Back end: carries out commands on the receive and transmit stores,
// keeps the flow state and drives the result register.
// Depends on xxfc_pkg and on the assertion macro header.
`default_nettype none
`include "xon_xoff_flow_control_top_macros.svh"

module xxfc_back #(
    parameter int RX_DEPTH = xxfc_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = xxfc_pkg::TX_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  xxfc_pkg::cfg_t       cfg,
    input  wire                  cmd_valid,
    input  xxfc_pkg::cmd_t       cmd,
    output logic                 cmd_pop,
    output logic                 res_valid,
    input  wire                  res_stall,
    output xxfc_pkg::result_t    res
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int RX_SW = RX_CW + 1;
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int TX_SW = TX_CW + 1;
    localparam int CMP_W = (RX_CW > xxfc_pkg::THR_W) ? RX_CW : xxfc_pkg::THR_W;

    // Stores and their registered read data.
    logic [xxfc_pkg::BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [xxfc_pkg::BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [xxfc_pkg::BYTE_W-1:0] rx_rd_data_reg;
    logic [xxfc_pkg::BYTE_W-1:0] tx_rd_data_reg;

    // Queue pointers and flow state.
    logic [RX_AW-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic [TX_AW-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;
    logic             peer_may_send_reg, peer_may_send_next;
    logic             sending_on_reg, sending_on_next;

    // Result staging.
    logic                pend_reg;
    xxfc_pkg::result_t   pend_res_reg;
    xxfc_pkg::sel_t      pend_sel_reg;
    logic                res_valid_reg;
    xxfc_pkg::result_t   res_reg;
    xxfc_pkg::result_t   res_merged;

    // Decision signals.
    logic                         fire;
    logic                         flow_on;
    logic                         send_ok;
    logic                         rx_full;
    logic                         tx_full;
    logic                         rx_push;
    logic                         tx_push;
    logic                         rx_pop;
    logic                         tx_pop;
    logic                         line_valid;
    logic [xxfc_pkg::BYTE_W-1:0]  line_byte;
    logic                         host_valid;
    logic                         drop;
    xxfc_pkg::sel_t               sel;
    logic [RX_SW-1:0]             rx_wr_sum;
    logic [RX_AW-1:0]             rx_wr_addr;
    logic [TX_SW-1:0]             tx_wr_sum;
    logic [TX_AW-1:0]             tx_wr_addr;
    xxfc_pkg::result_t            pend_res_next;

    assign flow_on = (cfg.flow_mode != 2'd0);
    assign send_ok = sending_on_reg || !flow_on;
    assign rx_full = (rx_count_reg == RX_CW'(RX_DEPTH));
    assign tx_full = (tx_count_reg == TX_CW'(TX_DEPTH));

    // A command starts only when no result is in flight and the output slot frees up.
    assign fire    = cmd_valid && !pend_reg && (!res_valid_reg || !res_stall);
    assign cmd_pop = fire;

    // Write addresses: read pointer plus fill count, wrapped at the depth.
    assign rx_wr_sum  = RX_SW'(rx_rd_ptr_reg) + RX_SW'(rx_count_reg);
    assign rx_wr_addr = (rx_wr_sum >= RX_SW'(RX_DEPTH)) ?
                        RX_AW'(rx_wr_sum - RX_SW'(RX_DEPTH)) : RX_AW'(rx_wr_sum);
    assign tx_wr_sum  = TX_SW'(tx_rd_ptr_reg) + TX_SW'(tx_count_reg);
    assign tx_wr_addr = (tx_wr_sum >= TX_SW'(TX_DEPTH)) ?
                        TX_AW'(tx_wr_sum - TX_SW'(TX_DEPTH)) : TX_AW'(tx_wr_sum);

    // Command execution.
    always_comb
    begin
        rx_rd_ptr_next     = rx_rd_ptr_reg;
        rx_count_next      = rx_count_reg;
        tx_rd_ptr_next     = tx_rd_ptr_reg;
        tx_count_next      = tx_count_reg;
        peer_may_send_next = peer_may_send_reg;
        sending_on_next    = sending_on_reg;
        rx_push            = 1'b0;
        tx_push            = 1'b0;
        rx_pop             = 1'b0;
        tx_pop             = 1'b0;
        line_valid         = 1'b0;
        line_byte          = '0;
        host_valid         = 1'b0;
        drop               = 1'b0;
        sel                = xxfc_pkg::SEL_NONE;
        unique case (cmd.kind)
            xxfc_pkg::KIND_RX_CTRL:
            begin
                sending_on_next = (cmd.data == xxfc_pkg::CODE_XON);
            end
            xxfc_pkg::KIND_RX_DATA:
            begin
                if (!rx_full)
                begin
                    rx_push       = 1'b1;
                    rx_count_next = rx_count_reg + 1'b1;
                end
                else
                begin
                    drop = 1'b1;
                end
                // Pause the peer once the level passes the high mark.
                if (flow_on && peer_may_send_reg &&
                    (CMP_W'(rx_count_next) > CMP_W'(cfg.high_threshold)))
                begin
                    line_valid         = 1'b1;
                    line_byte          = xxfc_pkg::CODE_XOFF;
                    peer_may_send_next = 1'b0;
                end
            end
            xxfc_pkg::KIND_HOST_READ:
            begin
                if (rx_count_reg != '0)
                begin
                    rx_pop         = 1'b1;
                    host_valid     = 1'b1;
                    sel            = xxfc_pkg::SEL_RX;
                    rx_count_next  = rx_count_reg - 1'b1;
                    rx_rd_ptr_next = (rx_rd_ptr_reg == RX_AW'(RX_DEPTH - 1)) ?
                                     '0 : rx_rd_ptr_reg + 1'b1;
                end
            end
            xxfc_pkg::KIND_HOST_WRITE:
            begin
                // Bypass the transmit store when it is empty and sending is allowed.
                if (send_ok && (tx_count_reg == '0))
                begin
                    line_valid = 1'b1;
                    line_byte  = cmd.data;
                end
                else if (!tx_full)
                begin
                    tx_push       = 1'b1;
                    tx_count_next = tx_count_reg + 1'b1;
                end
                else
                begin
                    drop = 1'b1;
                end
            end
            xxfc_pkg::KIND_TICK:
            begin
                // A due XON wins over queued data.
                if (flow_on && !peer_may_send_reg &&
                    (CMP_W'(rx_count_reg) < CMP_W'(cfg.low_threshold)))
                begin
                    line_valid         = 1'b1;
                    line_byte          = xxfc_pkg::CODE_XON;
                    peer_may_send_next = 1'b1;
                end
                else if (send_ok && (tx_count_reg != '0))
                begin
                    tx_pop         = 1'b1;
                    line_valid     = 1'b1;
                    sel            = xxfc_pkg::SEL_TX;
                    tx_count_next  = tx_count_reg - 1'b1;
                    tx_rd_ptr_next = (tx_rd_ptr_reg == TX_AW'(TX_DEPTH - 1)) ?
                                     '0 : tx_rd_ptr_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result fields known before the store read returns.
    always_comb
    begin
        pend_res_next.line_tx_valid   = line_valid;
        pend_res_next.line_tx_byte    = line_byte;
        pend_res_next.host_rx_valid   = host_valid;
        pend_res_next.host_rx_byte    = '0;
        pend_res_next.rx_level        = xxfc_pkg::RX_LVL_W'(rx_count_next);
        pend_res_next.tx_level        = xxfc_pkg::TX_LVL_W'(tx_count_next);
        pend_res_next.sending_enabled = sending_on_next || !flow_on;
        pend_res_next.dropped         = drop;
    end

    // Receive store: one write or one registered read per command.
    always_ff @(posedge clk)
    begin
        if (fire && rx_push)
        begin
            rx_mem[rx_wr_addr] <= cmd.data;
        end
        if (fire && rx_pop)
        begin
            rx_rd_data_reg <= rx_mem[rx_rd_ptr_reg];
        end
    end

    // Transmit store: one write or one registered read per command.
    always_ff @(posedge clk)
    begin
        if (fire && tx_push)
        begin
            tx_mem[tx_wr_addr] <= cmd.data;
        end
        if (fire && tx_pop)
        begin
            tx_rd_data_reg <= tx_mem[tx_rd_ptr_reg];
        end
    end

    // Queue pointers and flow state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_rd_ptr_reg     <= '0;
            rx_count_reg      <= '0;
            tx_rd_ptr_reg     <= '0;
            tx_count_reg      <= '0;
            peer_may_send_reg <= 1'b1;
            sending_on_reg    <= 1'b1;
        end
        else if (fire)
        begin
            rx_rd_ptr_reg     <= rx_rd_ptr_next;
            rx_count_reg      <= rx_count_next;
            tx_rd_ptr_reg     <= tx_rd_ptr_next;
            tx_count_reg      <= tx_count_next;
            peer_may_send_reg <= peer_may_send_next;
            sending_on_reg    <= sending_on_next;
        end
        else if (cfg.send_on_set)
        begin
            sending_on_reg <= 1'b1;
        end
    end

    // Pending stage control and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= fire;
            if (pend_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // The store byte is merged into the pending result.
    always_comb
    begin
        res_merged = pend_res_reg;
        unique case (pend_sel_reg)
            xxfc_pkg::SEL_RX: res_merged.host_rx_byte = rx_rd_data_reg;
            xxfc_pkg::SEL_TX: res_merged.line_tx_byte = tx_rd_data_reg;
            default: ;
        endcase
    end

    // Pending payload and output register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_res_reg <= pend_res_next;
            pend_sel_reg <= sel;
        end
        if (pend_reg)
        begin
            res_reg <= res_merged;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A started command lands in the pending stage, then in the output register.
    `XXFC_ASSERT_NEXT(a_fire_to_pend, clk, rst_n, fire, pend_reg)
    `XXFC_ASSERT_NEXT(a_pend_to_res, clk, rst_n, pend_reg, res_valid_reg && !pend_reg)
    // The output slot is always free when a pending result is loaded.
    `XXFC_ASSERT(a_slot_free, clk, rst_n, pend_reg |-> !res_valid_reg)
    // Fill counts stay within the store depths.
    `XXFC_ASSERT(a_levels, clk, rst_n,
                 (rx_count_reg <= RX_CW'(RX_DEPTH)) && (tx_count_reg <= TX_CW'(TX_DEPTH)))

endmodule

`default_nettype wire

>>> hw/rtl/xon_xoff_flow_control_top.sv
// XON/XOFF flow control. An accepted item is written into the command queue; the back end
// executes it and reads a store into its pending stage, then loads the output register.
// While a result is pending after the execute step and the registered store read that
// follows it, the back end starts no new command; items wait in the queue. Reset clears
// pointers, levels and flow state, loads the register defaults; the stores are not cleared and need no clearing pass.
`default_nettype none

module xon_xoff_flow_control_top #(
    parameter int RX_DEPTH = xxfc_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = xxfc_pkg::TX_DEPTH_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [xxfc_pkg::PADDR_W-1:0]   paddr,
    input  wire [xxfc_pkg::PDATA_W-1:0]   pwdata,
    output logic [xxfc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  wire                           item_valid,
    output logic                          item_stall,
    input  xxfc_pkg::item_t               item,
    output logic                          res_valid,
    input  wire                           res_stall,
    output xxfc_pkg::result_t             res
);

    xxfc_pkg::cfg_t cfg;
    xxfc_pkg::cmd_t q_cmd;
    xxfc_pkg::cmd_t head;
    logic           q_full;
    logic           q_push;
    logic           head_valid;
    logic           cmd_pop;

    // Configuration registers.
    xxfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept and classify.
    xxfc_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .flow_on    (cfg.flow_mode != 2'd0),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // Decoupling queue.
    xxfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Execute against the stores and deliver results.
    xxfc_back #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (head_valid),
        .cmd       (head),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire
